FILE: src/dvim_pkg.sv
// Shared types and constants for the default-valued id map.
// Used by default_valued_id_map_top and its port checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dvim_pkg;

    localparam int unsigned ID_W    = 16;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned BOUND_W = 11;

    // Input stream payload: tdata = {value, entity_id}, tuser = func.
    localparam int unsigned IN_DATA_W  = 48;
    // Output stream payload: tdata = {pad, rejected, bound_now, read_value}.
    localparam int unsigned OUT_DATA_W = 48;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // Register index of the default value (byte address 4 * index).
    localparam logic [0:0] REG_DEFAULT = 1'b0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_GET   = 2'd0,
        FUNC_SET   = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

endpackage : dvim_pkg

`default_nettype wire

FILE: src/default_valued_id_map_top.sv
// Default-valued id map: a directly indexed store with a high-water bound.
// Depends on dvim_pkg; holds the entry memory and its sequencer.
//
//  Channel  | Direction | Handshake         | Payload
//  ---------+-----------+-------------------+-------------------------------------------
//  s_*      | in        | s_tvalid/s_tready | tdata: entity_id, value; tuser: func
//  m_*      | out       | m_tvalid/m_tready | tdata: read_value, bound_now, rejected
//  APB      | in/out    | psel/penable      | default_value at byte address 0
//
// An operation reads the entry memory in its transfer cycle; the execute state then loads the
// output register. Deleting a top entry above entry 0 walks the entries below it, one entry
// per cycle, down to the first non-default entry or entry 0, before the result is loaded; a
// clear first writes every entry with the default value. After reset a clearing pass over
// every entry holds s_tready low, while configuration is taken at all times. A full output
// register parks the result; input waits.
`timescale 1ns / 1ps
`default_nettype none

module default_valued_id_map_top #(
    parameter int unsigned CAPACITY = 1024
) (
    input  wire                               clk,
    input  wire                               rst_n,
    // APB configuration port
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [dvim_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire  [dvim_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [dvim_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    // Input stream
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [dvim_pkg::IN_DATA_W-1:0]    s_tdata,   // [15:0] entity_id, [47:16] value
    input  wire  [dvim_pkg::FUNC_W-1:0]       s_tuser,   // [1:0] func
    // Output stream
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [dvim_pkg::OUT_DATA_W-1:0]   m_tdata    // [31:0] read_value,
                                                         // [42:32] bound_now, [43] rejected
);

    import dvim_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned BW = $clog2(CAPACITY + 1);
    localparam logic [ID_W:0]   CAP_EXT  = (ID_W + 1)'(CAPACITY);
    localparam logic [AW-1:0]   LAST_ADR = AW'(CAPACITY - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_CLEAR,
        ST_RESP
    } state_t;

    state_t                 state_reg, state_next;
    logic [FUNC_W-1:0]      op_func_reg, op_func_next;
    logic [ID_W-1:0]        op_id_reg, op_id_next;
    logic [VAL_W-1:0]       op_val_reg, op_val_next;
    logic [BW-1:0]          bound_reg, bound_next;
    logic [AW-1:0]          clr_addr_reg, clr_addr_next;
    logic                   clr_resp_reg, clr_resp_next;
    logic [VAL_W-1:0]       res_rd_reg, res_rd_next;
    logic                   res_rej_reg, res_rej_next;
    logic [VAL_W-1:0]       default_reg, default_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [VAL_W-1:0]       out_rd_reg, out_rd_next;
    logic [BOUND_W-1:0]     out_bound_reg, out_bound_next;
    logic                   out_rej_reg, out_rej_next;

    logic [VAL_W-1:0]       mem [CAPACITY];
    logic [VAL_W-1:0]       mem_rdata_reg;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [VAL_W-1:0]       mem_wdata;
    logic [AW-1:0]          mem_raddr;

    logic                   out_free;
    logic                   id_in_range;
    logic [AW-1:0]          op_addr;
    logic [ID_W:0]          id_plus1;
    logic [ID_W:0]          bound_ext;
    logic [BW-1:0]          bound_m2;
    logic                   cfg_we;
    logic                   go_walk;
    logic                   go_clear;
    logic                   ex_rej;
    logic [VAL_W-1:0]       ex_rd;

    assign pready   = 1'b1;
    assign cfg_we   = psel && penable && pwrite && (paddr[2] == REG_DEFAULT);
    assign prdata   = (paddr[2] == REG_DEFAULT) ? default_reg : '0;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(OUT_DATA_W - VAL_W - BOUND_W - 1)'(0), out_rej_reg, out_bound_reg,
                       out_rd_reg};

    assign out_free    = !m_tvalid_reg || m_tready;
    assign id_in_range = ({1'b0, op_id_reg} < CAP_EXT);
    assign op_addr     = op_id_reg[AW-1:0];
    assign id_plus1    = {1'b0, op_id_reg} + (ID_W + 1)'(1);
    assign bound_ext   = (ID_W + 1)'(bound_reg);
    assign bound_m2    = bound_reg - BW'(2);

    always_comb
    begin
        state_next     = state_reg;
        op_func_next   = op_func_reg;
        op_id_next     = op_id_reg;
        op_val_next    = op_val_reg;
        bound_next     = bound_reg;
        clr_addr_next  = clr_addr_reg;
        clr_resp_next  = clr_resp_reg;
        res_rd_next    = res_rd_reg;
        res_rej_next   = res_rej_reg;
        default_next   = cfg_we ? pwdata : default_reg;
        m_tvalid_next  = m_tready ? 1'b0 : m_tvalid_reg;
        out_rd_next    = out_rd_reg;
        out_bound_next = out_bound_reg;
        out_rej_next   = out_rej_reg;
        mem_we         = 1'b0;
        mem_waddr      = op_addr;
        mem_wdata      = op_val_reg;
        mem_raddr      = op_addr;
        go_walk        = 1'b0;
        go_clear       = 1'b0;
        ex_rej         = 1'b0;
        ex_rd          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                mem_raddr = s_tdata[AW-1:0];
                if (s_tvalid)
                begin
                    op_func_next = s_tuser;
                    op_id_next   = s_tdata[ID_W-1:0];
                    op_val_next  = s_tdata[ID_W+VAL_W-1:ID_W];
                    state_next   = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                // Prefetch the entry below the target for a possible walk-down.
                mem_raddr = op_addr - AW'(1);
                case (op_func_reg)
                    FUNC_GET:
                    begin
                        ex_rd = id_in_range ? mem_rdata_reg : default_reg;
                    end
                    FUNC_SET:
                    begin
                        if (op_val_reg == default_reg)
                        begin
                            if (id_in_range)
                            begin
                                mem_we = 1'b1;
                                if (bound_ext == id_plus1)
                                begin
                                    bound_next = BW'(op_id_reg);
                                    go_walk    = (op_id_reg != '0);
                                end
                            end
                        end
                        else if (!id_in_range)
                        begin
                            ex_rej = 1'b1;
                        end
                        else
                        begin
                            mem_we = 1'b1;
                            if (id_plus1 > bound_ext)
                            begin
                                bound_next = BW'(id_plus1);
                            end
                        end
                    end
                    FUNC_CLEAR:
                    begin
                        go_clear = 1'b1;
                    end
                    default:
                    begin
                        ex_rd = '0;
                    end
                endcase

                res_rd_next  = ex_rd;
                res_rej_next = ex_rej;
                if (go_walk)
                begin
                    state_next = ST_WALK;
                end
                else if (go_clear)
                begin
                    bound_next    = '0;
                    clr_addr_next = '0;
                    clr_resp_next = 1'b1;
                    state_next    = ST_CLEAR;
                end
                else if (out_free)
                begin
                    m_tvalid_next  = 1'b1;
                    out_rd_next    = ex_rd;
                    out_rej_next   = ex_rej;
                    out_bound_next = BOUND_W'(bound_next);
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end

            ST_WALK:
            begin
                // The registered read data is entry bound_reg - 1; the next read is issued
                // one entry lower so that the walk moves one entry per cycle.
                mem_raddr    = bound_m2[AW-1:0];
                res_rd_next  = '0;
                res_rej_next = 1'b0;
                if (mem_rdata_reg == default_reg)
                begin
                    bound_next = bound_reg - BW'(1);
                    if (bound_reg == BW'(1))
                    begin
                        state_next = ST_RESP;
                    end
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end

            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = default_reg;
                clr_addr_next = clr_addr_reg + AW'(1);
                res_rd_next   = '0;
                res_rej_next  = 1'b0;
                if (clr_addr_reg == LAST_ADR)
                begin
                    state_next = clr_resp_reg ? ST_RESP : ST_IDLE;
                end
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    m_tvalid_next  = 1'b1;
                    out_rd_next    = res_rd_reg;
                    out_rej_next   = res_rej_reg;
                    out_bound_next = BOUND_W'(bound_reg);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // Reset starts the clearing pass with no result to deliver.
            state_reg     <= ST_CLEAR;
            op_func_reg   <= '0;
            op_id_reg     <= '0;
            op_val_reg    <= '0;
            bound_reg     <= '0;
            clr_addr_reg  <= '0;
            clr_resp_reg  <= 1'b0;
            res_rd_reg    <= '0;
            res_rej_reg   <= 1'b0;
            default_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
            out_rd_reg    <= '0;
            out_bound_reg <= '0;
            out_rej_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_func_reg   <= op_func_next;
            op_id_reg     <= op_id_next;
            op_val_reg    <= op_val_next;
            bound_reg     <= bound_next;
            clr_addr_reg  <= clr_addr_next;
            clr_resp_reg  <= clr_resp_next;
            res_rd_reg    <= res_rd_next;
            res_rej_reg   <= res_rej_next;
            default_reg   <= default_next;
            m_tvalid_reg  <= m_tvalid_next;
            out_rd_reg    <= out_rd_next;
            out_bound_reg <= out_bound_next;
            out_rej_reg   <= out_rej_next;
        end
    end

    // Entry memory: one write port, one read port with registered data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

endmodule : default_valued_id_map_top

`default_nettype wire

FILE: src/dvim_checker.sv
// Port-level checker for default_valued_id_map_top, with its bind statement.
// Depends on dvim_pkg and on the port list of the top level.
`timescale 1ns / 1ps
`default_nettype none

module dvim_port_checker #(
    parameter int unsigned CAPACITY = 1024
) (
    input wire                               clk,
    input wire                               rst_n,
    input wire                               s_tvalid,
    input wire                               s_tready,
    input wire                               m_tvalid,
    input wire                               m_tready,
    input wire [dvim_pkg::OUT_DATA_W-1:0]    m_tdata
);

    import dvim_pkg::*;

    logic [VAL_W-1:0]   chk_rd;
    logic [BOUND_W-1:0] chk_bound;
    logic               chk_rej;

    assign chk_rd    = m_tdata[VAL_W-1:0];
    assign chk_bound = m_tdata[VAL_W+BOUND_W-1:VAL_W];
    assign chk_rej   = m_tdata[VAL_W+BOUND_W];

    // A result that waits for its transfer keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output result changed while stalled");

    // One item at a time: the input is closed in the cycle after a transfer.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted in consecutive cycles");

    // The clearing pass keeps the input closed right after reset.
    a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !s_tready)
        else $error("input open before the clearing pass finished");

    // A rejected set reads nothing, and the bound never exceeds the capacity.
    a_result_sane: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(chk_rej && (chk_rd != '0)) &&
                     ((CAPACITY > 2047) || (chk_bound <= BOUND_W'(CAPACITY))))
        else $error("inconsistent result fields");

endmodule : dvim_port_checker

bind default_valued_id_map_top dvim_port_checker #(.CAPACITY(CAPACITY)) u_dvim_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
